>>> sv/pixel_color_section_marker_unit_assert.svh
// Assertion macros for the pixel color section marker.
// Each check is clocked on clk_i and is disabled while rst_ni is low.
`ifndef PIXEL_COLOR_SECTION_MARKER_UNIT_ASSERT_SVH
`define PIXEL_COLOR_SECTION_MARKER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define PCSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define PCSM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define PCSM_ASSERT(label, prop, msg)
`define PCSM_ASSERT_NEVER(label, cond, msg)

`endif

`endif

>>> sv/pcsm_pkg.sv
package pcsm_pkg;

  // Frame geometry limits.
  localparam int unsigned MAX_FRAME_DIM = 4096;
  localparam int unsigned MIN_FRAME_DIM = 3;
  localparam int unsigned DIM_W         = 13;  // width of a dimension register
  localparam int unsigned POS_W         = 12;  // width of a column or row counter

  // Reset values of the configuration registers.
  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 13'd480;

  // Configuration register indexes.
  localparam int unsigned      CFG_IDX_W         = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_MODE = 2'd2;

  // Color thresholds.
  localparam logic [7:0] BRIGHT_LO   = 8'd240;
  localparam logic [7:0] ORANGE_G_LO = 8'd130;
  localparam logic [7:0] ORANGE_G_HI = 8'd180;
  localparam logic [7:0] ORANGE_B_HI = 8'd50;
  localparam logic [7:0] DARK_HI     = 8'd100;

  // Sections of the 3x3 grid.
  localparam int unsigned  NUM_SECTIONS = 9;
  localparam logic [3:0]   SECTION_NONE = 4'd9;

  // Reciprocal of three, scaled by 2^DIM_W and rounded up.
  localparam logic [25:0]  THIRD_RECIP  = 26'd2731;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_GREEN  = 2'd1,
    CLS_RED    = 2'd2,
    CLS_ORANGE = 2'd3
  } pixel_class_e;

  // One result item.
  typedef struct packed {
    pixel_class_e            pixel_class;
    logic [3:0]              pixel_section;
    logic                    frame_done;
    logic [NUM_SECTIONS-1:0] section_hits;
    logic [3:0]              first_hit_section;
  } result_t;

  // Clamp a dimension register to the supported range.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v < DIM_W'(MIN_FRAME_DIM)) begin
      r = DIM_W'(MIN_FRAME_DIM);
    end else if (v > DIM_W'(MAX_FRAME_DIM)) begin
      r = DIM_W'(MAX_FRAME_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Floor of v / 3 for v up to MAX_FRAME_DIM, by reciprocal multiplication.
  function automatic logic [POS_W-1:0] third_of(input logic [DIM_W-1:0] v);
    logic [25:0] prod;
    prod = {13'd0, v} * THIRD_RECIP;
    return prod[24:13];
  endfunction

  // Index of the last column or row for a clamped dimension.
  function automatic logic [POS_W-1:0] last_of(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] m;
    m = v - DIM_W'(1);
    return m[POS_W-1:0];
  endfunction

  // Lowest set flag, or SECTION_NONE when no flag is set.
  function automatic logic [3:0] first_set(input logic [NUM_SECTIONS-1:0] f);
    logic [3:0] r;
    r = SECTION_NONE;
    for (int i = NUM_SECTIONS - 1; i >= 0; i--) begin
      if (f[i]) begin
        r = 4'(i);
      end
    end
    return r;
  endfunction

endpackage

>>> sv/pixel_color_section_marker_unit.sv
// Pixel color section marker: classifies RGB pixels and flags 3x3 frame sections.
// Each result is registered in the output register, or in the skid register on a stall.
// Throughput: one pixel per cycle while the skid register is empty.
// A two-entry output stage (output register plus skid register) keeps input ready registered.
// Reset: counters and section flags clear, geometry returns to 640x480 in marker mode.
module pixel_color_section_marker_unit
  import pcsm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_wdata_i,

  // Pixel input stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]

  // Result output stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // pixel_class[1:0], pixel_section[5:2], section_hits[14:6],
  // first_hit_section[18:15], zero[23:19]
  output logic [23:0]          m_axis_tdata,
  output logic                 m_axis_tlast   // frame_done
);

  `include "pixel_color_section_marker_unit_assert.svh"

  // Geometry derived at write time.
  logic [POS_W-1:0] col_last_q, col_third_q, col_two_q;
  logic [POS_W-1:0] row_last_q, row_third_q, row_two_q;
  logic             obstacle_q;

  logic [DIM_W-1:0] cfg_eff;
  logic [POS_W-1:0] cfg_third;
  logic [POS_W-1:0] cfg_last;

  assign cfg_eff   = eff_dim(cfg_wdata_i);
  assign cfg_third = third_of(cfg_eff);
  assign cfg_last  = last_of(cfg_eff);

  // Configuration registers hold the clamped limits and section borders.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_last_q  <= last_of(RST_FRAME_WIDTH);
      col_third_q <= third_of(RST_FRAME_WIDTH);
      col_two_q   <= POS_W'({third_of(RST_FRAME_WIDTH), 1'b0});
      row_last_q  <= last_of(RST_FRAME_HEIGHT);
      row_third_q <= third_of(RST_FRAME_HEIGHT);
      row_two_q   <= POS_W'({third_of(RST_FRAME_HEIGHT), 1'b0});
      obstacle_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH: begin
          col_last_q  <= cfg_last;
          col_third_q <= cfg_third;
          col_two_q   <= {cfg_third[POS_W-2:0], 1'b0};
        end
        REG_FRAME_HEIGHT: begin
          row_last_q  <= cfg_last;
          row_third_q <= cfg_third;
          row_two_q   <= {cfg_third[POS_W-2:0], 1'b0};
        end
        REG_OBSTACLE_MODE: begin
          obstacle_q  <= cfg_wdata_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Pixel fields.
  logic [7:0] red, green, blue;
  assign red   = s_axis_tdata[7:0];
  assign green = s_axis_tdata[15:8];
  assign blue  = s_axis_tdata[23:16];

  // Color classification.
  pixel_class_e cls;
  always_comb begin
    cls = CLS_NONE;
    if (obstacle_q) begin
      if (red > BRIGHT_LO && green > ORANGE_G_LO && green < ORANGE_G_HI &&
          blue < ORANGE_B_HI) begin
        cls = CLS_ORANGE;
      end
    end else if (red < DARK_HI && green > BRIGHT_LO && blue < DARK_HI) begin
      cls = CLS_GREEN;
    end else if (red > BRIGHT_LO && green < DARK_HI && blue < DARK_HI) begin
      cls = CLS_RED;
    end
  end

  // Raster position and section of the current pixel.
  logic [POS_W-1:0]        col_q, col_d, row_q, row_d;
  logic [NUM_SECTIONS-1:0] flags_q, flags_d, flags_hit;
  logic [1:0]              col_sec, row_sec;
  logic [3:0]              section;
  logic                    row_end, last;

  assign col_sec = (col_q < col_third_q) ? 2'd0 : (col_q < col_two_q) ? 2'd1 : 2'd2;
  assign row_sec = (row_q < row_third_q) ? 2'd0 : (row_q < row_two_q) ? 2'd1 : 2'd2;
  assign section = {1'b0, row_sec, 1'b0} + {2'b00, row_sec} + {2'b00, col_sec};
  assign row_end = (col_q >= col_last_q);
  assign last    = row_end && (row_q >= row_last_q);

  // Flag update; the frame's last pixel reports and clears the flags.
  assign flags_hit = flags_q |
                     ((cls != CLS_NONE) ? (NUM_SECTIONS'(1) << section) : '0);

  result_t res;
  always_comb begin
    res.pixel_class       = cls;
    res.pixel_section     = section;
    res.frame_done        = last;
    res.section_hits      = last ? flags_hit : '0;
    res.first_hit_section = last ? first_set(flags_hit) : SECTION_NONE;
  end

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    flags_d = flags_q;
    if (in_xfer) begin
      flags_d = last ? '0 : flags_hit;
      if (row_end) begin
        col_d = '0;
        row_d = last ? '0 : row_q + POS_W'(1);
      end else begin
        col_d = col_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      flags_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      flags_q <= flags_d;
    end
  end

  // Output register with a skid register behind it.
  result_t out_q, skid_q;
  logic    out_v_q, skid_v_q;
  logic    out_free;

  assign out_free      = !out_v_q || m_axis_tready;
  assign s_axis_tready = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : res;
    end
    if (!out_free && in_xfer) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = out_q.frame_done;
  assign m_axis_tdata  = {5'd0, out_q.first_hit_section, out_q.section_hits,
                          out_q.pixel_section, out_q.pixel_class};

  // Checks on the output stage and the flag bookkeeping.
  `PCSM_ASSERT(a_skid_behind_out, skid_v_q |-> out_v_q, "skid entry without output entry")
  `PCSM_ASSERT(a_flags_cleared, (in_xfer && last) |=> (flags_q == '0),
               "section flags not cleared after frame end")
  `PCSM_ASSERT(a_summary_only_at_end,
               (out_v_q && !out_q.frame_done) |->
               (out_q.section_hits == '0 && out_q.first_hit_section == SECTION_NONE),
               "frame summary on a pixel that is not the last")
  `PCSM_ASSERT_NEVER(a_section_range, out_v_q && (out_q.pixel_section > 4'd8),
                     "pixel section out of range")

endmodule
